/* design/xbn_pkg.sv */
// Package for the XML byte normalizer and UTF-8 checker.
// Holds payload structs, queue entry type, byte and status codes.
// No dependencies.
package xbn_pkg;

    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BOM_B0   = 8'hEF;
    localparam logic [7:0] BOM_B1   = 8'hBB;
    localparam logic [7:0] BOM_B2   = 8'hBF;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_NUL     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_document;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic [1:0] status;
        logic       last;
    } t_out_req;

    // One raw byte (or the end-of-document marker) handed from front to back.
    typedef struct packed {
        logic [7:0] raw_byte;
        logic       is_status;
        logic       last;
    } t_q_entry;

endpackage

/* design/xbn_front.sv */
// Front end: accepts raw bytes, strips a leading byte-order mark and
// expands each request into queue entries. Depends on xbn_pkg.
module xbn_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  xbn_pkg::t_in_req  i_in_req,
    output logic              o_q_push,
    output xbn_pkg::t_q_entry o_q_entry,
    input  logic              i_q_full
);
    import xbn_pkg::*;

    typedef enum logic [3:0] {
        MP_START = 4'b0001,
        MP_EF    = 4'b0010,
        MP_EFBB  = 4'b0100,
        MP_PAST  = 4'b1000
    } t_mark_phase;

    t_mark_phase r_phase, n_phase;
    logic [7:0]  r_seq_byte [4];
    logic [3:0]  r_seq_stat;
    logic [2:0]  r_len;
    logic [1:0]  r_pos;
    logic        r_busy;

    logic [7:0]  n_seq_byte [4];
    logic [3:0]  n_seq_stat;
    logic [2:0]  n_len;
    logic        accept, done, entry_last;
    logic [7:0]  b;

    assign b          = i_in_req.in_byte;
    assign entry_last = ({1'b0, r_pos} + 3'd1) == r_len;
    assign o_q_push   = r_busy && !i_q_full;
    assign done       = o_q_push && entry_last;
    assign o_in_ready = !r_busy || done;
    assign accept     = i_in_valid && o_in_ready;

    assign o_q_entry.raw_byte  = r_seq_byte[r_pos];
    assign o_q_entry.is_status = r_seq_stat[r_pos];
    assign o_q_entry.last      = entry_last;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_seq_byte[k] = b;
        end
        n_seq_stat = '0;
        n_len      = 3'd0;
        n_phase    = r_phase;
        unique case (r_phase)
            MP_START: begin
                if (b == BOM_B0) begin
                    n_phase = MP_EF;
                end else begin
                    n_phase       = MP_PAST;
                    n_seq_byte[0] = b;
                    n_len         = 3'd1;
                end
            end
            MP_EF: begin
                if (b == BOM_B1) begin
                    n_phase = MP_EFBB;
                end else begin
                    n_phase       = MP_PAST;
                    n_seq_byte[0] = BOM_B0;
                    n_seq_byte[1] = b;
                    n_len         = 3'd2;
                end
            end
            MP_EFBB: begin
                n_phase = MP_PAST;
                if (b != BOM_B2) begin
                    n_seq_byte[0] = BOM_B0;
                    n_seq_byte[1] = BOM_B1;
                    n_seq_byte[2] = b;
                    n_len         = 3'd3;
                end
            end
            MP_PAST: begin
                n_seq_byte[0] = b;
                n_len         = 3'd1;
            end
            default: begin
                n_phase = MP_START;
            end
        endcase
        if (i_in_req.end_of_document) begin
            // release a partial mark before the status
            if (n_phase == MP_EF) begin
                n_seq_byte[0] = BOM_B0;
                n_len         = 3'd1;
            end else if (n_phase == MP_EFBB) begin
                n_seq_byte[0] = BOM_B0;
                n_seq_byte[1] = BOM_B1;
                n_len         = 3'd2;
            end
            n_seq_stat[n_len[1:0]] = 1'b1;
            n_len   = n_len + 3'd1;
            n_phase = MP_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MP_START;
            r_busy  <= 1'b0;
            r_pos   <= 2'd0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_busy  <= n_len != 3'd0;
                r_pos   <= 2'd0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (o_q_push) begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seq_byte <= n_seq_byte;
            r_seq_stat <= n_seq_stat;
            r_len      <= n_len;
        end
    end

endmodule

/* design/xbn_queue.sv */
// Short FIFO of raw-byte entries between front and back.
// Depends on xbn_pkg.
module xbn_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  xbn_pkg::t_q_entry i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output xbn_pkg::t_q_entry o_entry,
    output logic              o_empty
);
    import xbn_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_q_entry        r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [PW:0]     r_cnt;

    assign o_full  = r_cnt == (PW+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* design/xbn_back.sv */
// Back end: CR/LF folding, Latin-1 widening, XML UTF-8 checking and
// the output register. Depends on xbn_pkg.
module xbn_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_encoding_mode,
    input  xbn_pkg::t_q_entry i_entry,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output xbn_pkg::t_out_req o_out_req
);
    import xbn_pkg::*;

    localparam logic [1:0] CLS_TWO   = 2'd0;
    localparam logic [1:0] CLS_THREE = 2'd1;
    localparam logic [1:0] CLS_FOUR  = 2'd2;

    logic        r_half, r_cr, r_nul, r_bad;
    logic [1:0]  r_cont, r_cls;
    logic [20:0] r_acc;
    logic        r_ov;
    t_out_req    r_out;

    logic        n_half, n_cr, n_nul, n_bad;
    logic [1:0]  n_cont, n_cls;
    logic [20:0] n_acc, acc_sh, min_cp;
    logic        step, emit, pop, is_stat, clear_doc;
    logic [7:0]  b, eb;
    t_out_req    n_out;

    assign b      = i_entry.raw_byte;
    assign step   = !i_empty && (!r_ov || i_out_ready);
    assign o_pop  = pop;
    assign acc_sh = {r_acc[14:0], eb[5:0]};
    assign min_cp = (r_cls == CLS_TWO)   ? 21'h80 :
                    (r_cls == CLS_THREE) ? 21'h800 : 21'h10000;

    // normalize
    always_comb begin
        emit      = 1'b0;
        pop       = 1'b0;
        is_stat   = 1'b0;
        clear_doc = 1'b0;
        eb        = b;
        n_half    = r_half;
        n_cr      = r_cr;
        n_nul     = r_nul;
        if (step) begin
            if (i_entry.is_status) begin
                is_stat   = 1'b1;
                pop       = 1'b1;
                clear_doc = 1'b1;
            end else if (r_half) begin
                emit   = 1'b1;
                pop    = 1'b1;
                eb     = {2'b10, b[5:0]};
                n_half = 1'b0;
            end else begin
                if (b == BYTE_NUL) begin
                    n_nul = 1'b1;
                end
                n_cr = 1'b0;
                if (r_cr && b == BYTE_LF) begin
                    pop = 1'b1;
                end else if (b == BYTE_CR) begin
                    emit = 1'b1;
                    pop  = 1'b1;
                    eb   = BYTE_LF;
                    n_cr = 1'b1;
                end else if (i_encoding_mode && b[7]) begin
                    emit   = 1'b1;
                    eb     = {6'b110000, b[7:6]};
                    n_half = 1'b1;
                end else begin
                    emit = 1'b1;
                    pop  = 1'b1;
                end
            end
        end
    end

    // XML UTF-8 check of each emitted byte
    always_comb begin
        n_bad  = r_bad;
        n_cont = r_cont;
        n_acc  = r_acc;
        n_cls  = r_cls;
        if (emit && !r_bad) begin
            if (r_cont == 2'd0) begin
                if (!eb[7]) begin
                    if (eb < 8'h20 && eb != BYTE_TAB && eb != BYTE_LF &&
                        eb != BYTE_CR) begin
                        n_bad = 1'b1;
                    end
                end else if (eb[7:5] == 3'b110) begin
                    n_cont = 2'd1;
                    n_acc  = {16'd0, eb[4:0]};
                    n_cls  = CLS_TWO;
                end else if (eb[7:4] == 4'b1110) begin
                    n_cont = 2'd2;
                    n_acc  = {17'd0, eb[3:0]};
                    n_cls  = CLS_THREE;
                end else if (eb[7:3] == 5'b11110) begin
                    n_cont = 2'd3;
                    n_acc  = {18'd0, eb[2:0]};
                    n_cls  = CLS_FOUR;
                end else begin
                    n_bad = 1'b1;
                end
            end else if (eb[7:6] != 2'b10) begin
                n_bad  = 1'b1;
                n_cont = 2'd0;
            end else begin
                n_acc  = acc_sh;
                n_cont = r_cont - 2'd1;
                if (r_cont == 2'd1) begin
                    if (acc_sh < min_cp || acc_sh > 21'h10FFFF ||
                        (acc_sh >= 21'hD800 && acc_sh <= 21'hDFFF) ||
                        acc_sh == 21'hFFFE || acc_sh == 21'hFFFF) begin
                        n_bad = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        n_out.out_byte  = eb;
        n_out.is_status = 1'b0;
        n_out.status    = ST_VALID;
        n_out.last      = i_entry.last && pop;
        if (is_stat) begin
            n_out.out_byte  = 8'd0;
            n_out.is_status = 1'b1;
            n_out.last      = i_entry.last;
            if (r_nul) begin
                n_out.status = ST_NUL;
            end else if (r_bad || r_cont != 2'd0) begin
                n_out.status = ST_INVALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_half <= 1'b0;
            r_cr   <= 1'b0;
            r_nul  <= 1'b0;
            r_bad  <= 1'b0;
            r_cont <= 2'd0;
            r_acc  <= '0;
            r_cls  <= CLS_TWO;
        end else begin
            if (emit || is_stat) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (clear_doc) begin
                r_half <= 1'b0;
                r_cr   <= 1'b0;
                r_nul  <= 1'b0;
                r_bad  <= 1'b0;
                r_cont <= 2'd0;
                r_acc  <= '0;
                r_cls  <= CLS_TWO;
            end else begin
                r_half <= n_half;
                r_cr   <= n_cr;
                r_nul  <= n_nul;
                r_bad  <= n_bad;
                r_cont <= n_cont;
                r_acc  <= n_acc;
                r_cls  <= n_cls;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit || is_stat) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_req   = r_out;

endmodule

/* design/xml_byte_normalize_and_utf8_check_top.sv */
// XML byte normalizer and UTF-8 checker, top level.
// Instantiates xbn_front, xbn_queue, xbn_back; depends on xbn_pkg.
//
// Takes a document one byte per request and returns normalized UTF-8 bytes
// plus one status result after the byte flagged end_of_document (status
// 0 valid, 1 NUL present, 2 invalid XML UTF-8; NUL wins). A leading EF BB BF
// is stripped; the first one or two bytes are held until the mark is
// decided. CR becomes LF and an LF right after CR is dropped. With
// encoding_mode = 1 each byte of 0x80 and above is widened to two UTF-8
// bytes. Output is one result per clock while the consumer is ready and
// entries are queued; a widened Latin-1 byte gives two results, and a
// request up to seven when two held mark bytes and the current byte are
// all widened and the status follows. A held or stripped mark byte queues
// nothing; an LF dropped after CR is still queued and popped but gives no
// result. The front end queues one entry per cycle while the queue is not
// full (up to four per request) and takes a new request in the cycle it
// queues the last entry of the previous one; a 4-entry queue decouples it
// from the back end, so the input keeps flowing until the queue fills while
// the output register holds a result. Write encoding_mode only between
// documents with the block drained; the configuration port is always ready.
module xml_byte_normalize_and_utf8_check_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  xbn_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output xbn_pkg::t_out_req o_out_req,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);
    import xbn_pkg::*;

    logic     r_encoding_mode;
    logic     q_push, q_full, q_pop, q_empty;
    t_q_entry q_wr_entry, q_rd_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_encoding_mode <= i_cfg_data;
        end
    end

    // mark stripping and expansion of each request into queue entries
    xbn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .o_q_push   (q_push),
        .o_q_entry  (q_wr_entry),
        .i_q_full   (q_full)
    );

    xbn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (q_rd_entry),
        .o_empty (q_empty)
    );

    // normalization, checking and output register
    xbn_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_encoding_mode (r_encoding_mode),
        .i_entry         (q_rd_entry),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_req       (o_out_req)
    );

endmodule

/* design/xbn_checker.sv */
// Port-level checks for the XML byte normalizer, bound to the top level.
// Depends on xbn_pkg and xml_byte_normalize_and_utf8_check_top.
module xbn_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input xbn_pkg::t_in_req  i_in_req,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input xbn_pkg::t_out_req o_out_req
);
    import xbn_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_req))
        else $error("waiting request changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))
        else $error("stalled result changed");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.is_status |->
            o_out_req.last && o_out_req.out_byte == 8'd0 &&
            (o_out_req.status == ST_VALID || o_out_req.status == ST_NUL ||
             o_out_req.status == ST_INVALID))
        else $error("malformed status result");

    a_byte_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_req.is_status |-> o_out_req.status == ST_VALID)
        else $error("byte result carries status");

    a_no_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_req.is_status |-> o_out_req.out_byte != BYTE_CR)
        else $error("CR left in output");

endmodule

bind xml_byte_normalize_and_utf8_check_top xbn_checker u_xbn_checker (.*);
